[hw/rtl/mhpq_pkg.sv]
// Package for the min-heap priority queue: microcode step, control word and status types,
// and the read-only microprogram that the sequencer steps through.
// No dependencies.
package mhpq_pkg;

   localparam int PORT_VALUE_W = 32;
   localparam int PORT_COUNT_W = 7;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH0,
      S_UP_RD,
      S_UP_CMP,
      S_POP0,
      S_POP1,
      S_DN_RDL,
      S_DN_RDR,
      S_DN_CMP,
      S_PLACE,
      S_FINISH
   } step_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_PARENT,
      RD_LAST,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_PUSH_INIT,
      OP_POP_INIT,
      OP_LOAD_X,
      OP_LOAD_CAND,
      OP_UP,
      OP_DOWN,
      OP_PLACE,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_POP_REQ,
      C_FULL,
      C_EMPTY,
      C_ROOT,
      C_NO_KID,
      C_UP_STOP,
      C_DN_STOP
   } cond_type;

   typedef struct packed {
      rd_sel_type rd;
      op_type     op;
      cond_type   cond;
      step_type   jump;
      step_type   next;
   } ctrl_word_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic root;
      logic no_kid;
      logic up_stop;
      logic dn_stop;
   } flags_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = '{rd: RD_NONE, op: OP_NONE, cond: C_ALWAYS, jump: S_IDLE, next: S_IDLE};
      case (step)
         S_IDLE:   cw = '{RD_NONE,   OP_ACCEPT,    C_POP_REQ, S_POP0,   S_PUSH0};
         S_PUSH0:  cw = '{RD_NONE,   OP_PUSH_INIT, C_FULL,    S_FINISH, S_UP_RD};
         S_UP_RD:  cw = '{RD_PARENT, OP_NONE,      C_ROOT,    S_PLACE,  S_UP_CMP};
         S_UP_CMP: cw = '{RD_NONE,   OP_UP,        C_UP_STOP, S_FINISH, S_UP_RD};
         S_POP0:   cw = '{RD_LAST,   OP_POP_INIT,  C_EMPTY,   S_FINISH, S_POP1};
         S_POP1:   cw = '{RD_NONE,   OP_LOAD_X,    C_ALWAYS,  S_DN_RDL, S_DN_RDL};
         S_DN_RDL: cw = '{RD_LEFT,   OP_NONE,      C_NO_KID,  S_PLACE,  S_DN_RDR};
         S_DN_RDR: cw = '{RD_RIGHT,  OP_LOAD_CAND, C_ALWAYS,  S_DN_CMP, S_DN_CMP};
         S_DN_CMP: cw = '{RD_NONE,   OP_DOWN,      C_DN_STOP, S_FINISH, S_DN_RDL};
         S_PLACE:  cw = '{RD_NONE,   OP_PLACE,     C_ALWAYS,  S_FINISH, S_FINISH};
         S_FINISH: cw = '{RD_NONE,   OP_FINISH,    C_ALWAYS,  S_IDLE,   S_IDLE};
         default:  cw = '{RD_NONE,   OP_NONE,      C_ALWAYS,  S_IDLE,   S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

[hw/rtl/min_heap_priority_queue.sv]
// Top level of the min-heap priority queue: microcode sequencer and heap datapath.
// Depends on mhpq_pkg, mhpq_seq and mhpq_dp.
//
// A request is taken at a rising edge with start high and busy low. req_type 0 pushes
// req_value, req_type 1 pops the minimum. Busy stays high while the request is worked on.
// Each request gives one result: rsp_valid is high for exactly one cycle with rsp_status,
// rsp_top_value (minimum after the operation, zero when empty), rsp_element_count and
// rsp_is_empty. The receiver cannot stall; results are taken when shown.
// The heap lives in one RAM with one write and one registered read port, which sets
// the pace. Per level, a push reads the parent and compares; a pop reads the left child,
// reads the right child and compares. A push climbs at most log2(HEAP_DEPTH) levels and
// a pop descends at most one level fewer. A refused request goes straight to its result.
// A new request may be given in the cycle that shows the previous result. Reset clears
// the element count and the sequencer; the heap RAM needs no clearing, since only
// entries below the count are ever used.
module min_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int HEAP_DEPTH  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic signed [PORT_VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic signed [PORT_VALUE_W-1:0] rsp_top_value,
   output logic [PORT_COUNT_W-1:0]        rsp_element_count,
   output logic                           rsp_is_empty
);

   ctrl_word_type cw;
   flags_type     flags;

   mhpq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .flags    (flags),
      .cw       (cw),
      .busy     (busy)
   );

   mhpq_dp #(
      .HEAP_DEPTH  (HEAP_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cw                (cw),
      .req_value         (req_value),
      .flags             (flags),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_top_value     (rsp_top_value),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule

[hw/rtl/mhpq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mhpq_seq.sv]
// Microcode sequencer: step counter, control-word ROM lookup and conditional jumps.
// Depends on mhpq_pkg.
module mhpq_seq
   import mhpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_type,
   input  flags_type     flags,
   output ctrl_word_type cw,
   output logic          busy
);

   step_type step_ff;
   step_type step_in;
   logic     cond_true;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      cw = ucode_rom(step_ff);
      case (cw.cond)
         C_ALWAYS:  cond_true = 1'b1;
         C_POP_REQ: cond_true = req_type;
         C_FULL:    cond_true = flags.full;
         C_EMPTY:   cond_true = flags.empty;
         C_ROOT:    cond_true = flags.root;
         C_NO_KID:  cond_true = flags.no_kid;
         C_UP_STOP: cond_true = flags.up_stop;
         C_DN_STOP: cond_true = flags.dn_stop;
         default:   cond_true = 1'b1;
      endcase
      if (step_ff == S_IDLE && !start) begin
         step_in = S_IDLE;
      end else if (cond_true) begin
         step_in = cw.jump;
      end else begin
         step_in = cw.next;
      end
   end

   assign busy = (step_ff != S_IDLE);

endmodule

[hw/rtl/mhpq_dp.sv]
// Heap datapath: heap RAM, position, count and moving-value registers, result registers.
// Depends on mhpq_pkg and mhpq_ram.
module mhpq_dp
   import mhpq_pkg::*;
#(
   parameter int HEAP_DEPTH  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_word_type                  cw,
   input  logic signed [PORT_VALUE_W-1:0] req_value,
   output flags_type                      flags,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic signed [PORT_VALUE_W-1:0] rsp_top_value,
   output logic [PORT_COUNT_W-1:0]        rsp_element_count,
   output logic                           rsp_is_empty
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int KW = AW + 2;

   logic [AW-1:0]                  pos_ff, pos_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic signed [VALUE_WIDTH-1:0]  x_ff, x_in;
   logic signed [VALUE_WIDTH-1:0]  cand_ff, cand_in;
   logic signed [VALUE_WIDTH-1:0]  top_ff, top_in;
   status_type                     status_ff, status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic signed [PORT_VALUE_W-1:0] rsp_top_ff, rsp_top_in;
   logic [PORT_COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                           rsp_empty_ff, rsp_empty_in;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic signed [VALUE_WIDTH-1:0]  wr_data;
   logic [AW-1:0]                  rd_addr;
   logic [VALUE_WIDTH-1:0]         rd_data;
   logic signed [VALUE_WIDTH-1:0]  rd_val;

   logic [AW-1:0]                  parent_idx;
   logic [CW-1:0]                  last_full;
   logic [KW-1:0]                  left_idx, right_idx;
   logic                           full, empty, has_right, use_right, up_gt, dn_gt;
   logic signed [VALUE_WIDTH-1:0]  child_val;
   logic [AW-1:0]                  child_idx;

   mhpq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (HEAP_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_val     = rd_data;
   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign last_full  = cnt_ff - CW'(1);
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = {1'b0, pos_ff, 1'b0} + KW'(2);
   assign full       = (cnt_ff == CW'(HEAP_DEPTH));
   assign empty      = (cnt_ff == '0);
   assign has_right  = (right_idx < KW'(cnt_ff));
   assign use_right  = has_right && (cand_ff > rd_val);
   assign child_val  = use_right ? rd_val : cand_ff;
   assign child_idx  = use_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
   assign up_gt      = (rd_val > x_ff);
   assign dn_gt      = (x_ff > child_val);

   always_comb begin
      flags.full    = full;
      flags.empty   = empty;
      flags.root    = (pos_ff == '0);
      flags.no_kid  = (left_idx >= KW'(cnt_ff));
      flags.up_stop = !up_gt;
      flags.dn_stop = !dn_gt;
   end

   always_comb begin
      case (cw.rd)
         RD_PARENT: rd_addr = parent_idx;
         RD_LAST:   rd_addr = last_full[AW-1:0];
         RD_LEFT:   rd_addr = left_idx[AW-1:0];
         RD_RIGHT:  rd_addr = right_idx[AW-1:0];
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      cand_in       = cand_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = x_ff;
      case (cw.op)
         OP_ACCEPT: begin
            x_in = VALUE_WIDTH'(req_value);
         end
         OP_PUSH_INIT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_DONE;
               pos_in    = cnt_ff[AW-1:0];
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         OP_POP_INIT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in = ST_DONE;
               pos_in    = '0;
               cnt_in    = last_full;
            end
         end
         OP_LOAD_X: begin
            x_in = rd_val;
         end
         OP_LOAD_CAND: begin
            cand_in = rd_val;
         end
         OP_UP: begin
            wr_en = 1'b1;
            if (up_gt) begin
               wr_data = rd_val;
               pos_in  = parent_idx;
            end
         end
         OP_DOWN: begin
            wr_en = 1'b1;
            if (dn_gt) begin
               wr_data = child_val;
               pos_in  = child_idx;
            end
         end
         OP_PLACE: begin
            wr_en = 1'b1;
         end
         OP_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_top_in    = empty ? '0 : PORT_VALUE_W'(top_ff);
            rsp_count_in  = PORT_COUNT_W'(cnt_ff);
            rsp_empty_in  = empty;
         end
         default: begin
         end
      endcase
      top_in = (wr_en && wr_addr == '0) ? wr_data : top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      x_ff          <= x_in;
      cand_ff       <= cand_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;

endmodule

[hw/rtl/mhpq_chk.sv]
// Port-level checker for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue.
module mhpq_chk
   import mhpq_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_type,
   input logic signed [PORT_VALUE_W-1:0] req_value,
   input logic                           rsp_valid,
   input logic [1:0]                     rsp_status,
   input logic signed [PORT_VALUE_W-1:0] rsp_top_value,
   input logic [PORT_COUNT_W-1:0]        rsp_element_count,
   input logic                           rsp_is_empty
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted request did not raise busy.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe lasted more than one cycle.");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("Request finished without a result.");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_top_value == '0)
      else $error("Empty heap reported a nonzero minimum.");

   a_refused_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_element_count == '0)
      else $error("Refused pop reported a nonempty heap.");

endmodule

bind min_heap_priority_queue mhpq_chk u_chk (.*);

[bench/tb_min_heap_priority_queue.sv]
// Self-checking testbench for min_heap_priority_queue: push and pop requests with random
// gaps, checked against a behavioral heap kept in the bench. Depends on mhpq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;
   import mhpq_pkg::*;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 900;
   localparam bit OP_PUSH      = 1'b0;
   localparam bit OP_POP       = 1'b1;

   typedef struct {
      logic                           kind;
      logic signed [PORT_VALUE_W-1:0] value;
      int                             gap_pct;
   } heap_req_type;

   typedef struct {
      status_type                     status;
      logic signed [PORT_VALUE_W-1:0] top;
      logic [PORT_COUNT_W-1:0]        count;
      logic                           empty;
   } heap_rsp_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           req_type = 1'b0;
   logic signed [PORT_VALUE_W-1:0] req_value = '0;
   logic                           busy;
   logic                           rsp_valid;
   logic [1:0]                     rsp_status;
   logic signed [PORT_VALUE_W-1:0] rsp_top_value;
   logic [PORT_COUNT_W-1:0]        rsp_element_count;
   logic                           rsp_is_empty;

   heap_req_type                   pending_reqs[$];
   heap_rsp_type                   expected_rsps[$];
   heap_req_type                   active_req;
   logic signed [PORT_VALUE_W-1:0] heap_model[DEPTH];
   int                             heap_size = 0;
   int                             queued_count = 0;
   int                             taken_count = 0;
   int                             error_count = 0;
   int                             gap_pct = 0;
   bit                             stimulus_ready = 1'b0;

   min_heap_priority_queue uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_top_value     (rsp_top_value),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void swap_entries(input int i, input int j);
      logic signed [PORT_VALUE_W-1:0] t;
      t             = heap_model[i];
      heap_model[i] = heap_model[j];
      heap_model[j] = t;
   endfunction

   // Applies one request to the behavioral heap and returns the result it should give.
   function automatic heap_rsp_type apply_heap_request(input heap_req_type r);
      heap_rsp_type rsp;
      int           pos;
      int           up;
      int           kid;
      rsp.status = ST_DONE;
      if (r.kind == OP_PUSH) begin
         if (heap_size >= DEPTH) begin
            rsp.status = ST_FULL;
         end else begin
            heap_model[heap_size] = r.value;
            pos = heap_size;
            heap_size++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(heap_model[up] > heap_model[pos])) break;
               swap_entries(up, pos);
               pos = up;
            end
         end
      end else begin
         if (heap_size == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            heap_size--;
            heap_model[0] = heap_model[heap_size];
            pos = 0;
            forever begin
               kid = pos * 2 + 1;
               if (kid >= heap_size) break;
               if (kid + 1 < heap_size && heap_model[kid] > heap_model[kid + 1]) kid++;
               if (!(heap_model[pos] > heap_model[kid])) break;
               swap_entries(pos, kid);
               pos = kid;
            end
         end
      end
      rsp.top   = (heap_size > 0) ? heap_model[0] : '0;
      rsp.count = PORT_COUNT_W'(heap_size);
      rsp.empty = (heap_size == 0);
      return rsp;
   endfunction

   function automatic logic signed [PORT_VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         5, 6, 7: return PORT_VALUE_W'($signed($urandom_range(8)) - 4);
         8:       return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         9:       return $urandom_range(1) ? 32'sh8000_0001 : 32'sh7fff_fffe;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_request(input logic kind, input logic signed [PORT_VALUE_W-1:0] value);
      heap_req_type r;
      case ((queued_count * 4) / (RANDOM_ITEMS + 20))
         0:       gap_pct = 0;
         1:       gap_pct = 76;
         2:       gap_pct = 0;
         default: gap_pct = 21;
      endcase
      r.kind    = kind;
      r.value   = value;
      r.gap_pct = gap_pct;
      pending_reqs.push_back(r);
      queued_count++;
   endtask

   initial begin : stimulus
      int  fill_est;
      int  refusals;
      int  want_refusals;
      int  seg;
      bit  do_push;

      add_request(OP_POP, 32'sh1234_5678);
      add_request(OP_PUSH, 32'sh0000_0000);
      add_request(OP_PUSH, 32'sh8000_0000);
      add_request(OP_PUSH, 32'sh7fff_ffff);
      add_request(OP_PUSH, -32'sd1);
      add_request(OP_PUSH, 32'sd5);
      add_request(OP_PUSH, 32'sd5);
      add_request(OP_PUSH, -32'sd1);
      add_request(OP_PUSH, 32'sh8000_0000);
      add_request(OP_POP, 32'shffff_ffff);
      add_request(OP_POP, 32'sh0000_0000);
      add_request(OP_PUSH, 32'sd1);
      repeat (8) add_request(OP_POP, $urandom);
      fill_est = 0;
      while (queued_count < RANDOM_ITEMS + 20) begin
         seg = $urandom_range(2);
         if (seg == 0) begin
            refusals      = 0;
            want_refusals = $urandom_range(1, 4);
            while (refusals < want_refusals) begin
               do_push = ($urandom_range(99) < 85);
               if (do_push) begin
                  if (fill_est == DEPTH) refusals++;
                  else fill_est++;
               end else if (fill_est > 0) begin
                  fill_est--;
               end
               add_request(do_push ? OP_PUSH : OP_POP, pick_value());
            end
         end else if (seg == 1) begin
            refusals      = 0;
            want_refusals = $urandom_range(1, 3);
            while (refusals < want_refusals) begin
               do_push = ($urandom_range(99) < 15);
               if (!do_push) begin
                  if (fill_est == 0) refusals++;
                  else fill_est--;
               end else if (fill_est < DEPTH) begin
                  fill_est++;
               end
               add_request(do_push ? OP_PUSH : OP_POP, pick_value());
            end
         end else begin
            repeat (40) begin
               do_push = $urandom_range(1);
               if (do_push && fill_est < DEPTH) fill_est++;
               if (!do_push && fill_est > 0) fill_est--;
               add_request(do_push ? OP_PUSH : OP_POP, pick_value());
            end
         end
      end
      stimulus_ready = 1'b1;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin : req_driver
      bit load_next;
      load_next = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_heap_request(active_req));
            taken_count++;
            load_next = 1'b1;
         end else if (!start) begin
            load_next = 1'b1;
         end
         if (load_next) begin
            if (pending_reqs.size() > 0 &&
                $urandom_range(99) >= pending_reqs[0].gap_pct) begin
               active_req = pending_reqs.pop_front();
               start     <= 1'b1;
               req_type  <= active_req.kind;
               req_value <= active_req.value;
            end else begin
               start     <= 1'b0;
               req_type  <= $urandom_range(1);
               req_value <= $urandom;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      heap_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, status %0d top %0d count %0d empty %0d",
                     $time, rsp_status, rsp_top_value, rsp_element_count, rsp_is_empty);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_top_value !== want.top) begin
               $display("%0t: top_value expected %0d actual %0d", $time, want.top,
                        rsp_top_value);
               error_count++;
            end
            if (rsp_element_count !== want.count) begin
               $display("%0t: element_count expected %0d actual %0d", $time, want.count,
                        rsp_element_count);
               error_count++;
            end
            if (rsp_is_empty !== want.empty) begin
               $display("%0t: is_empty expected %0d actual %0d", $time, want.empty,
                        rsp_is_empty);
               error_count++;
            end
         end
      end
   end

   initial begin
      wait (stimulus_ready && taken_count == queued_count);
      wait (expected_rsps.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
